@@ sv/qteb_pkg.sv @@
// Shared constants, widths and the arctangent table for the quaternion to Euler bins block.
// No dependencies.
package qteb_pkg;

   localparam int ANGLE_BINS   = 18;
   localparam int CORDIC_STEPS = 16;
   localparam int ISQ_STEPS    = 29;

   localparam int QW   = 16;  // quaternion component
   localparam int PW   = 32;  // product of two components
   localparam int OPW  = 34;  // atan2 operands before the CORDIC
   localparam int SW   = 30;  // clamped asin argument
   localparam int RAD_W = 57; // radicand 2^56 - s^2
   localparam int ISW  = 58;  // square root working width
   localparam int SQW  = 29;  // square root result
   localparam int CW   = 38;  // CORDIC vector width
   localparam int ACC_W = 33; // angle accumulator, units of pi / 2^30
   localparam int BW   = 5;
   localparam int BINW = 8;

   localparam int LATENCY = 3 + ISQ_STEPS + 1 + CORDIC_STEPS + 1;

   localparam logic signed [OPW-1:0]   ONE_Q28     = OPW'(64'sd268435456);
   localparam logic signed [ACC_W-1:0] ANG_PI      = ACC_W'(64'sd1073741824);
   localparam logic signed [ACC_W-1:0] ANG_HALF_PI = ACC_W'(64'sd536870912);

   function automatic logic signed [ACC_W-1:0] atan_units(input logic [4:0] idx);
      logic signed [ACC_W-1:0] val;
      unique case (idx)
         5'd0:  val = ACC_W'(268435456);
         5'd1:  val = ACC_W'(158466703);
         5'd2:  val = ACC_W'(83729454);
         5'd3:  val = ACC_W'(42502378);
         5'd4:  val = ACC_W'(21333666);
         5'd5:  val = ACC_W'(10677233);
         5'd6:  val = ACC_W'(5339919);
         5'd7:  val = ACC_W'(2670123);
         5'd8:  val = ACC_W'(1335082);
         5'd9:  val = ACC_W'(667543);
         5'd10: val = ACC_W'(333772);
         5'd11: val = ACC_W'(166886);
         5'd12: val = ACC_W'(83443);
         5'd13: val = ACC_W'(41722);
         5'd14: val = ACC_W'(20861);
         5'd15: val = ACC_W'(10430);
         5'd16: val = ACC_W'(5215);
         5'd17: val = ACC_W'(2608);
         5'd18: val = ACC_W'(1304);
         5'd19: val = ACC_W'(652);
         5'd20: val = ACC_W'(326);
         5'd21: val = ACC_W'(163);
         5'd22: val = ACC_W'(81);
         5'd23: val = ACC_W'(41);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/qteb_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Depends on qteb_pkg.
module qteb_isqrt (
   input  logic                        clock,
   input  logic [qteb_pkg::RAD_W-1:0]  radicand,
   output logic [qteb_pkg::SQW-1:0]    root
);
   import qteb_pkg::*;

   logic [ISW-1:0] v_ff [ISQ_STEPS];
   logic [ISW-1:0] r_ff [ISQ_STEPS];

   for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
      localparam logic [ISW-1:0] BIT = ISW'(1) << (2 * (ISQ_STEPS - 1 - k));
      logic [ISW-1:0] v_prev, r_prev, trial, v_in, r_in;

      if (k == 0) begin : g_first
         assign v_prev = ISW'(radicand);
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (v_prev >= trial) begin
            v_in = v_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            v_in = v_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[k] <= v_in;
         r_ff[k] <= r_in;
      end
   end

   assign root = r_ff[ISQ_STEPS-1][SQW-1:0];

endmodule

@@ sv/qteb_cordic.sv @@
// Pipelined vectoring CORDIC that returns atan2(y, x) in units of pi / 2^30.
// Depends on qteb_pkg.
module qteb_cordic (
   input  logic                               clock,
   input  logic signed [qteb_pkg::CW-1:0]     y_val,
   input  logic signed [qteb_pkg::CW-1:0]     x_val,
   output logic signed [qteb_pkg::ACC_W-1:0]  angle
);
   import qteb_pkg::*;

   logic signed [CW-1:0]    x_ff [CORDIC_STEPS+1];
   logic signed [CW-1:0]    y_ff [CORDIC_STEPS+1];
   logic signed [ACC_W-1:0] acc_ff [CORDIC_STEPS+1];
   logic                    fix_ff [CORDIC_STEPS+1];
   logic signed [ACC_W-1:0] fixval_ff [CORDIC_STEPS+1];

   logic signed [CW-1:0]    x0_in, y0_in;
   logic signed [ACC_W-1:0] acc0_in, fixval0_in;
   logic                    fix0_in;

   // An axis-aligned vector gets its exact angle; a vector in the left
   // half plane is first turned by a quarter turn.
   always_comb begin
      x0_in      = x_val;
      y0_in      = y_val;
      acc0_in    = '0;
      fix0_in    = 1'b0;
      fixval0_in = '0;
      priority if (y_val == '0) begin
         fix0_in    = 1'b1;
         fixval0_in = x_val[CW-1] ? ANG_PI : '0;
      end else if (x_val == '0) begin
         fix0_in    = 1'b1;
         fixval0_in = y_val[CW-1] ? -ANG_HALF_PI : ANG_HALF_PI;
      end else if (x_val[CW-1]) begin
         if (!y_val[CW-1]) begin
            x0_in   = y_val;
            y0_in   = -x_val;
            acc0_in = ANG_HALF_PI;
         end else begin
            x0_in   = -y_val;
            y0_in   = x_val;
            acc0_in = -ANG_HALF_PI;
         end
      end else begin
         acc0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]      <= x0_in;
      y_ff[0]      <= y0_in;
      acc_ff[0]    <= acc0_in;
      fix_ff[0]    <= fix0_in;
      fixval_ff[0] <= fixval0_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      logic signed [CW-1:0]    xs, ys, x_in, y_in;
      logic signed [ACC_W-1:0] acc_in;

      always_comb begin
         xs = x_ff[i] >>> i;
         ys = y_ff[i] >>> i;
         if (!y_ff[i][CW-1]) begin
            x_in   = x_ff[i] + ys;
            y_in   = y_ff[i] - xs;
            acc_in = acc_ff[i] + atan_units(5'(i));
         end else begin
            x_in   = x_ff[i] - ys;
            y_in   = y_ff[i] + xs;
            acc_in = acc_ff[i] - atan_units(5'(i));
         end
      end

      always_ff @(posedge clock) begin
         x_ff[i+1]      <= x_in;
         y_ff[i+1]      <= y_in;
         acc_ff[i+1]    <= acc_in;
         fix_ff[i+1]    <= fix_ff[i];
         fixval_ff[i+1] <= fixval_ff[i];
      end
   end

   assign angle = fix_ff[CORDIC_STEPS] ? fixval_ff[CORDIC_STEPS] : acc_ff[CORDIC_STEPS];

endmodule

@@ sv/quaternion_to_euler_bins.sv @@
// Top level: quaternion to roll, pitch and yaw bins.
// Depends on qteb_pkg, qteb_isqrt and qteb_cordic.
// Pipeline: 50 register stages from the edge that accepts start up to rsp_valid
// (3 product and sum stages, 29 square root stages, 17 CORDIC stages, 1 binning stage).
// Throughput: one beat per cycle, set by the fully unrolled square root and CORDIC pipelines;
// busy stays low. Synchronous reset clears only the valid bits; no results appear until new
// beats pass.
module quaternion_to_euler_bins (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [qteb_pkg::QW-1:0]  req_quat_w,
   input  logic signed [qteb_pkg::QW-1:0]  req_quat_x,
   input  logic signed [qteb_pkg::QW-1:0]  req_quat_y,
   input  logic signed [qteb_pkg::QW-1:0]  req_quat_z,
   output logic                            rsp_valid,
   output logic [qteb_pkg::BW-1:0]         rsp_roll_bin,
   output logic [qteb_pkg::BW-1:0]         rsp_pitch_bin,
   output logic [qteb_pkg::BW-1:0]         rsp_yaw_bin
);
   import qteb_pkg::*;

   logic [LATENCY-1:0] valid_ff, valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[LATENCY-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: component products.
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      wx_ff <= req_quat_w * req_quat_x;
      yz_ff <= req_quat_y * req_quat_z;
      xx_ff <= req_quat_x * req_quat_x;
      yy_ff <= req_quat_y * req_quat_y;
      wy_ff <= req_quat_w * req_quat_y;
      zx_ff <= req_quat_z * req_quat_x;
      wz_ff <= req_quat_w * req_quat_z;
      xy_ff <= req_quat_x * req_quat_y;
      zz_ff <= req_quat_z * req_quat_z;
   end

   // Stage 2: atan2 operands and the clamped asin argument.
   logic signed [OPW-1:0] ry_in, rx_in, py_in, px_in, sd;
   logic signed [OPW-1:0] ry_ff, rx_ff, py_ff, px_ff;
   logic signed [SW-1:0]  s_in, s_ff;

   always_comb begin
      ry_in = (OPW'(wx_ff) + OPW'(yz_ff)) <<< 1;
      rx_in = ONE_Q28 - ((OPW'(xx_ff) + OPW'(yy_ff)) <<< 1);
      py_in = (OPW'(wz_ff) + OPW'(xy_ff)) <<< 1;
      px_in = ONE_Q28 - ((OPW'(yy_ff) + OPW'(zz_ff)) <<< 1);
      sd    = (OPW'(wy_ff) - OPW'(zx_ff)) <<< 1;
      priority if (sd > ONE_Q28) begin
         s_in = SW'(ONE_Q28);
      end else if (sd < -ONE_Q28) begin
         s_in = SW'(-ONE_Q28);
      end else begin
         s_in = SW'(sd);
      end
   end

   always_ff @(posedge clock) begin
      ry_ff <= ry_in;
      rx_ff <= rx_in;
      py_ff <= py_in;
      px_ff <= px_in;
      s_ff  <= s_in;
   end

   // Stage 3: radicand 2^56 - s^2; the other operands move into the delay line.
   logic signed [2*SW-1:0] sq;
   logic [RAD_W-1:0]       rad_ff;
   logic signed [OPW-1:0]  ry_d_ff [ISQ_STEPS+1];
   logic signed [OPW-1:0]  rx_d_ff [ISQ_STEPS+1];
   logic signed [OPW-1:0]  py_d_ff [ISQ_STEPS+1];
   logic signed [OPW-1:0]  px_d_ff [ISQ_STEPS+1];
   logic signed [SW-1:0]   s_d_ff  [ISQ_STEPS+1];

   assign sq = s_ff * s_ff;

   always_ff @(posedge clock) begin
      rad_ff     <= (RAD_W'(1) << (RAD_W - 1)) - RAD_W'(sq);
      ry_d_ff[0] <= ry_ff;
      rx_d_ff[0] <= rx_ff;
      py_d_ff[0] <= py_ff;
      px_d_ff[0] <= px_ff;
      s_d_ff[0]  <= s_ff;
      for (int k = 1; k <= ISQ_STEPS; k++) begin
         ry_d_ff[k] <= ry_d_ff[k-1];
         rx_d_ff[k] <= rx_d_ff[k-1];
         py_d_ff[k] <= py_d_ff[k-1];
         px_d_ff[k] <= px_d_ff[k-1];
         s_d_ff[k]  <= s_d_ff[k-1];
      end
   end

   logic [SQW-1:0] root;

   qteb_isqrt u_isqrt (
      .clock    (clock),
      .radicand (rad_ff),
      .root     (root)
   );

   // Delay line entry ISQ_STEPS lines up with the square root output.
   logic signed [ACC_W-1:0] roll_ang, pitch_ang, yaw_ang;

   qteb_cordic u_roll (
      .clock (clock),
      .y_val (CW'(ry_d_ff[ISQ_STEPS])),
      .x_val (CW'(rx_d_ff[ISQ_STEPS])),
      .angle (roll_ang)
   );

   qteb_cordic u_pitch (
      .clock (clock),
      .y_val (CW'(s_d_ff[ISQ_STEPS])),
      .x_val (CW'(root)),
      .angle (pitch_ang)
   );

   qteb_cordic u_yaw (
      .clock (clock),
      .y_val (CW'(py_d_ff[ISQ_STEPS])),
      .x_val (CW'(px_d_ff[ISQ_STEPS])),
      .angle (yaw_ang)
   );

   // Binning: clamp to the span, offset to non-negative, scale and truncate.
   logic [ACC_W-1:0]      roll_u, pitch_u, yaw_u;
   logic [ACC_W+BINW-1:0] roll_p, pitch_p, yaw_p;
   logic [BW-1:0]         roll_ff, pitch_ff, yaw_ff;

   always_comb begin
      roll_u  = (roll_ang > ANG_PI) ? ACC_W'(ANG_PI + ANG_PI) :
                (roll_ang < -ANG_PI) ? '0 : ACC_W'(roll_ang + ANG_PI);
      yaw_u   = (yaw_ang > ANG_PI) ? ACC_W'(ANG_PI + ANG_PI) :
                (yaw_ang < -ANG_PI) ? '0 : ACC_W'(yaw_ang + ANG_PI);
      pitch_u = (pitch_ang > ANG_HALF_PI) ? ACC_W'(ANG_PI) :
                (pitch_ang < -ANG_HALF_PI) ? '0 : ACC_W'(pitch_ang + ANG_HALF_PI);
      roll_p  = (ACC_W+BINW)'(roll_u)  * (ACC_W+BINW)'(ANGLE_BINS);
      yaw_p   = (ACC_W+BINW)'(yaw_u)   * (ACC_W+BINW)'(ANGLE_BINS);
      pitch_p = (ACC_W+BINW)'(pitch_u) * (ACC_W+BINW)'(ANGLE_BINS);
   end

   always_ff @(posedge clock) begin
      roll_ff  <= roll_p[31 +: BW];
      pitch_ff <= pitch_p[30 +: BW];
      yaw_ff   <= yaw_p[31 +: BW];
   end

   assign rsp_valid     = valid_ff[LATENCY-1];
   assign rsp_roll_bin  = roll_ff;
   assign rsp_pitch_bin = pitch_ff;
   assign rsp_yaw_bin   = yaw_ff;

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_bin <= BW'(ANGLE_BINS))
      else $error("roll bin out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_bin <= BW'(ANGLE_BINS))
      else $error("pitch bin out of range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_yaw_bin <= BW'(ANGLE_BINS))
      else $error("yaw bin out of range");

   a_valid_chain: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LATENCY-2] |=> rsp_valid)
      else $error("beat lost in the pipeline");

endmodule
